// File: sv/swsp_pkg.sv
// Shared types, widths and helpers for the swept-sphere point marker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package swsp_pkg;

  localparam int COORD_BITS = 16;
  localparam int CURSOR_W   = 48;
  localparam int RAD_W      = 15;
  localparam int MARK_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Derived arithmetic widths. All intermediate results are exact.
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 2;
  localparam int DOT_W  = SUM_W + 1;
  localparam int RSQ_W  = 2 * RAD_W;
  localparam int BOX_W  = ((COORD_BITS > RAD_W) ? COORD_BITS : RAD_W) + 2;
  localparam int CMP_W  = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;
  localparam int LO_W   = (SUM_W + 1) / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int PP_W   = CMP_W + LO_W;
  localparam int A_W    = 2 * SUM_W;
  localparam int B_W    = CMP_W + SUM_W + 1;

  localparam logic [MARK_W-1:0] MARK_NONE      = MARK_W'(0);
  localparam logic [MARK_W-1:0] MARK_CLEANED   = MARK_W'(1);
  localparam logic [MARK_W-1:0] MARK_HIGHLIGHT = MARK_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CURSOR_NOW    = 3'd0,
    CFG_CURSOR_BEFORE = 3'd1,
    CFG_BRUSH_RADIUS  = 3'd2,
    CFG_CLEAR_MODE    = 3'd3,
    CFG_HIGHLIGHT     = 3'd4
  } cfg_idx_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [MARK_W-1:0] mark_t;

  typedef struct packed {
    coord_t [2:0]     now;
    coord_t [2:0]     prev;
    logic [RAD_W-1:0] radius;
    logic             clear;
    mark_t            highlight;
  } cfg_t;

  // Item leaving the geometry pipeline toward the cylinder compare.
  typedef struct packed {
    logic                    inbox;
    mark_t                   mark;
    logic [SUM_W-1:0]        pdsq;
    logic [SUM_W-1:0]        lensq;
    logic signed [DOT_W-1:0] dot;
    logic [RSQ_W-1:0]        rsq;
  } geom_t;

  // One signed lane of a packed cursor word; lanes past bit 63 read as zero.
  function automatic coord_t cursor_lane(logic [CURSOR_W-1:0] cur_bits, int unsigned idx);
    logic [63:0] ext;
    ext = 64'(cur_bits);
    if (idx * COORD_BITS >= 64) begin
      return '0;
    end
    return coord_t'(ext >> (idx * COORD_BITS));
  endfunction

endpackage

`default_nettype wire

// File: sv/swsp_cfg.sv
// Configuration register file of the swept-sphere point marker.
// Depends on swsp_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module swsp_cfg import swsp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  logic [CURSOR_W-1:0] now_q, now_d;
  logic [CURSOR_W-1:0] before_q, before_d;
  logic [RAD_W-1:0]    radius_q, radius_d;
  logic                clear_q, clear_d;
  mark_t               hl_q, hl_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    now_d    = now_q;
    before_d = before_q;
    radius_d = radius_q;
    clear_d  = clear_q;
    hl_d     = hl_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CURSOR_NOW:    now_d    = cfg_data_i[CURSOR_W-1:0];
        CFG_CURSOR_BEFORE: before_d = cfg_data_i[CURSOR_W-1:0];
        CFG_BRUSH_RADIUS:  radius_d = cfg_data_i[RAD_W-1:0];
        CFG_CLEAR_MODE:    clear_d  = cfg_data_i[0];
        CFG_HIGHLIGHT:     hl_d     = cfg_data_i[MARK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= '0;
      before_q <= '0;
      radius_q <= '0;
      clear_q  <= 1'b0;
      hl_q     <= MARK_HIGHLIGHT;
    end else begin
      now_q    <= now_d;
      before_q <= before_d;
      radius_q <= radius_d;
      clear_q  <= clear_d;
      hl_q     <= hl_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cfg_o.now[i]  = cursor_lane(now_q, i);
      cfg_o.prev[i] = cursor_lane(before_q, i);
    end
    cfg_o.radius    = radius_q;
    cfg_o.clear     = clear_q;
    cfg_o.highlight = hl_q;
  end

endmodule

`default_nettype wire

// File: sv/swsp_geom.sv
// Geometry pipeline: box reject, coordinate differences, squares and dot
// products, then the lane sums. Three register stages; depends on swsp_pkg.
`default_nettype none

module swsp_geom import swsp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  coord_t point_x_i,
  input  coord_t point_y_i,
  input  coord_t point_z_i,
  input  mark_t  mark_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output geom_t  out_o
);

  logic [2:0] v_q;
  logic [2:0] rdy;

  assign rdy[2]      = !v_q[2] || out_ready_i;
  assign rdy[1]      = !v_q[1] || rdy[2];
  assign rdy[0]      = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 1: box around the swept path, point minus current cursor.
  coord_t                  p [3];
  coord_t                  lo_c [3];
  coord_t                  hi_c [3];
  logic signed [BOX_W-1:0] box_lo [3];
  logic signed [BOX_W-1:0] box_hi [3];
  logic signed [BOX_W-1:0] rad_box;
  logic [2:0]              lane_in;
  logic signed [DIFF_W-1:0] pd_d [3];
  logic signed [DIFF_W-1:0] pd_q [3];
  logic                     inbox1_q;
  mark_t                    mark1_q;

  assign p[0]    = point_x_i;
  assign p[1]    = point_y_i;
  assign p[2]    = point_z_i;
  assign rad_box = signed'(BOX_W'(cfg_i.radius));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_c[i]    = (cfg_i.now[i] < cfg_i.prev[i]) ? cfg_i.now[i] : cfg_i.prev[i];
      hi_c[i]    = (cfg_i.now[i] > cfg_i.prev[i]) ? cfg_i.now[i] : cfg_i.prev[i];
      box_lo[i]  = BOX_W'(lo_c[i]) - rad_box;
      box_hi[i]  = BOX_W'(hi_c[i]) + rad_box;
      lane_in[i] = (BOX_W'(p[i]) >= box_lo[i]) && (BOX_W'(p[i]) <= box_hi[i]);
      pd_d[i]    = DIFF_W'(p[i]) - DIFF_W'(cfg_i.now[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      pd_q     <= pd_d;
      inbox1_q <= &lane_in;
      mark1_q  <= mark_i;
    end
  end

  // Stage 2: per-lane products. Cursor path terms come from the configuration,
  // which the user must hold still while items are in flight (not enforced).
  logic signed [DIFF_W-1:0] d_c [3];
  logic signed [PROD_W-1:0] pp_sq [3];
  logic signed [PROD_W-1:0] pp_dot [3];
  logic signed [PROD_W-1:0] pp_len [3];
  logic [RSQ_W-1:0]         rsq_c;
  logic [SQ_W-1:0]          sq_q [3];
  logic [SQ_W-1:0]          len_q [3];
  logic signed [PROD_W-1:0] dp_q [3];
  logic [RSQ_W-1:0]         rsq2_q;
  logic                     inbox2_q;
  mark_t                    mark2_q;

  assign rsq_c = cfg_i.radius * cfg_i.radius;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i]    = DIFF_W'(cfg_i.prev[i]) - DIFF_W'(cfg_i.now[i]);
      pp_sq[i]  = pd_q[i] * pd_q[i];
      pp_dot[i] = pd_q[i] * d_c[i];
      pp_len[i] = d_c[i] * d_c[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i]  <= pp_sq[i][SQ_W-1:0];
        len_q[i] <= pp_len[i][SQ_W-1:0];
        dp_q[i]  <= pp_dot[i];
      end
      rsq2_q   <= rsq_c;
      inbox2_q <= inbox1_q;
      mark2_q  <= mark1_q;
    end
  end

  // Stage 3: lane sums.
  geom_t res_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      res_q.pdsq  <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
      res_q.lensq <= SUM_W'(len_q[0]) + SUM_W'(len_q[1]) + SUM_W'(len_q[2]);
      res_q.dot   <= DOT_W'(dp_q[0]) + DOT_W'(dp_q[1]) + DOT_W'(dp_q[2]);
      res_q.rsq   <= rsq2_q;
      res_q.inbox <= inbox2_q;
      res_q.mark  <= mark2_q;
    end
  end

  assign out_o = res_q;

endmodule

`default_nettype wire

// File: sv/swsp_cyl.sv
// Sphere and cylinder decision: split products of the cross-multiplied
// distance test, their sums, the compare and the new mark. Depends on swsp_pkg.
`default_nettype none

module swsp_cyl import swsp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  geom_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output mark_t mark_out_o,
  output logic  mark_changed_o,
  output logic  cleaned_hit_o
);

  logic [2:0] v_q;
  logic [2:0] rdy;

  assign rdy[2]      = !v_q[2] || out_ready_i;
  assign rdy[1]      = !v_q[1] || rdy[2];
  assign rdy[0]      = !v_q[0] || rdy[1];
  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  // Stage 4: sphere test, cylinder preconditions and half-width products.
  // An unmoved cursor shows up as a zero path length.
  logic [SUM_W-1:0] dot_u;
  logic [LO_W-1:0]  len_lo;
  logic [HI_W-1:0]  len_hi;
  logic [LO_W-1:0]  dot_lo;
  logic [HI_W-1:0]  dot_hi;
  logic             sphere_d;
  logic             cyl_d;
  logic [PP_W-1:0]  pl_lo_d, pl_hi_d, rl_lo_d, rl_hi_d, dd_lo_d, dd_hi_d;
  logic [PP_W-1:0]  pl_lo_q, pl_hi_q, rl_lo_q, rl_hi_q, dd_lo_q, dd_hi_q;
  logic             sphere4_q, cyl4_q, inbox4_q;
  mark_t            mark4_q;

  assign dot_u    = in_i.dot[SUM_W-1:0];
  assign len_lo   = in_i.lensq[LO_W-1:0];
  assign len_hi   = in_i.lensq[SUM_W-1:LO_W];
  assign dot_lo   = dot_u[LO_W-1:0];
  assign dot_hi   = dot_u[SUM_W-1:LO_W];
  assign sphere_d = CMP_W'(in_i.pdsq) <= CMP_W'(in_i.rsq);
  assign cyl_d    = (in_i.lensq != '0) && !in_i.dot[DOT_W-1] && (dot_u <= in_i.lensq);
  assign pl_lo_d  = in_i.pdsq * len_lo;
  assign pl_hi_d  = in_i.pdsq * len_hi;
  assign rl_lo_d  = in_i.rsq * len_lo;
  assign rl_hi_d  = in_i.rsq * len_hi;
  assign dd_lo_d  = dot_u * dot_lo;
  assign dd_hi_d  = dot_u * dot_hi;

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      pl_lo_q   <= pl_lo_d;
      pl_hi_q   <= pl_hi_d;
      rl_lo_q   <= rl_lo_d;
      rl_hi_q   <= rl_hi_d;
      dd_lo_q   <= dd_lo_d;
      dd_hi_q   <= dd_hi_d;
      sphere4_q <= sphere_d;
      cyl4_q    <= cyl_d;
      inbox4_q  <= in_i.inbox;
      mark4_q   <= in_i.mark;
    end
  end

  // Stage 5: reassemble |pd|^2 * len^2 and r^2 * len^2 + dot^2.
  logic [A_W-1:0] lhs_q;
  logic [B_W-1:0] rhs_q;
  logic           sphere5_q, cyl5_q, inbox5_q;
  mark_t          mark5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1] && v_q[0]) begin
      lhs_q     <= (A_W'(pl_hi_q) << LO_W) + A_W'(pl_lo_q);
      rhs_q     <= (B_W'(rl_hi_q) << LO_W) + B_W'(rl_lo_q)
                 + (B_W'(dd_hi_q) << LO_W) + B_W'(dd_lo_q);
      sphere5_q <= sphere4_q;
      cyl5_q    <= cyl4_q;
      inbox5_q  <= inbox4_q;
      mark5_q   <= mark4_q;
    end
  end

  // Stage 6: final decision and output register.
  logic  hit;
  mark_t mark_d;
  logic  changed_d;
  logic  cleaned_d;
  mark_t mark_q;
  logic  changed_q;
  logic  cleaned_q;

  assign hit = inbox5_q && (sphere5_q || (cyl5_q && (B_W'(lhs_q) <= rhs_q)));

  always_comb begin
    mark_d    = MARK_NONE;
    changed_d = 1'b0;
    cleaned_d = 1'b0;
    if (mark5_q == MARK_CLEANED) begin
      mark_d = MARK_CLEANED;
    end else if (hit) begin
      changed_d = 1'b1;
      if (cfg_i.clear) begin
        mark_d    = MARK_CLEANED;
        cleaned_d = 1'b1;
      end else begin
        mark_d = cfg_i.highlight;
      end
    end else if (mark5_q != MARK_NONE) begin
      changed_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2] && v_q[1]) begin
      mark_q    <= mark_d;
      changed_q <= changed_d;
      cleaned_q <= cleaned_d;
    end
  end

  assign mark_out_o     = mark_q;
  assign mark_changed_o = changed_q;
  assign cleaned_hit_o  = cleaned_q;

endmodule

`default_nettype wire

// File: sv/swept_sphere_point_marker.sv
// Swept-sphere point marker: top level tying the configuration registers,
// the geometry pipeline and the cylinder decision together. Uses swsp_pkg.
//
// Usage: points enter on the in_ channel (x, y, z as signed Q5.10 and the
// current mark) and leave on the out_ channel with the new mark, a flag
// that the mark was written and a flag for a hit in clear mode. Both use
// valid/ready; a request is taken when valid and ready are high together.
// Configuration (cursor now and before, brush radius, clear mode and the
// highlight mark) is written through the cfg_ port, which is always ready;
// the user must write it only while no point is in flight (not enforced).
// The path from input request to result runs through three stages of
// differences, products and sums, then three of split products, their
// reassembly and the compare. One point is taken every cycle unless stalled.
// Each stage holds its own valid bit, so a stalled receiver backs up the
// pipeline stage by stage and empty stages still take new points.
// Reset empties the pipeline and sets the configuration registers to zero
// except the highlight mark, which becomes 100.
`default_nettype none

module swept_sphere_point_marker import swsp_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic [MARK_W-1:0]            mark_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [MARK_W-1:0]            mark_out_o,
  output logic                         mark_changed_o,
  output logic                         cleaned_hit_o
);

  cfg_t  cfg;
  geom_t geom;
  logic  geom_valid;
  logic  geom_ready;

  swsp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swsp_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .mark_i      (mark_in_i),
    .out_valid_o (geom_valid),
    .out_ready_i (geom_ready),
    .out_o       (geom)
  );

  swsp_cyl u_cyl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (geom_valid),
    .in_ready_o     (geom_ready),
    .in_i           (geom),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mark_out_o     (mark_out_o),
    .mark_changed_o (mark_changed_o),
    .cleaned_hit_o  (cleaned_hit_o)
  );

endmodule

`default_nettype wire

// File: dv/tb_swept_sphere_point_marker.sv
`timescale 1ns / 1ps
// Self-checking testbench for the swept-sphere point marker: directed geometry and
// randomized point traffic, with every result checked against an in-bench predictor.
// Depends on swsp_pkg and swept_sphere_point_marker.

module tb_swept_sphere_point_marker;
  import swsp_pkg::*;

  localparam int LATENCY     = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    mark_t mark;
    logic  changed;
    logic  cleaned;
  } mark_result_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  coord_t                point_x   = '0;
  coord_t                point_y   = '0;
  coord_t                point_z   = '0;
  mark_t                 mark_in   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mark_t                 mark_out;
  logic                  mark_changed;
  logic                  cleaned_hit;

  // Settings as the block should hold them.
  logic [CURSOR_W-1:0] cursor_now_q    = '0;
  logic [CURSOR_W-1:0] cursor_before_q = '0;
  logic [RAD_W-1:0]    radius_q        = '0;
  logic                clear_q         = 1'b0;
  mark_t               highlight_q     = MARK_HIGHLIGHT;

  mark_result_t pending_marks[$];
  int mismatches   = 0;
  int cycle_count  = 0;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;

  swept_sphere_point_marker i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .point_x_i      (point_x),
    .point_y_i      (point_y),
    .point_z_i      (point_z),
    .mark_in_i      (mark_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .mark_out_o     (mark_out),
    .mark_changed_o (mark_changed),
    .cleaned_hit_o  (cleaned_hit)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint lane_of(logic [CURSOR_W-1:0] cur_bits, int idx);
    return longint'($signed(cur_bits[idx*COORD_BITS +: COORD_BITS]));
  endfunction

  function automatic coord_t to_coord(int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic logic [CURSOR_W-1:0] pack_cursor(int x, int y, int z);
    return {to_coord(z), to_coord(y), to_coord(x)};
  endfunction

  // New mark of one point: box reject around the swept path, sphere at the
  // current cursor, then the exact cross-multiplied cylinder test.
  function automatic mark_result_t predict_mark(coord_t px, coord_t py, coord_t pz, mark_t m);
    longint          p[3];
    longint          c[3];
    longint          l[3];
    longint          r, pd, d, dot;
    longint unsigned pdsq, lensq, rsq;
    logic [127:0]    lhs, rhs;
    logic            inbox, moved, hit;
    mark_result_t    res;
    p[0]  = px;
    p[1]  = py;
    p[2]  = pz;
    r     = longint'(radius_q);
    rsq   = r * r;
    pdsq  = 0;
    lensq = 0;
    dot   = 0;
    inbox = 1'b1;
    moved = 1'b0;
    hit   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c[i] = lane_of(cursor_now_q, i);
      l[i] = lane_of(cursor_before_q, i);
      if (p[i] < ((c[i] < l[i] ? c[i] : l[i]) - r) ||
          p[i] > ((c[i] > l[i] ? c[i] : l[i]) + r)) begin
        inbox = 1'b0;
      end
      pd    = p[i] - c[i];
      d     = l[i] - c[i];
      pdsq  += pd * pd;
      lensq += d * d;
      dot   += pd * d;
      if (d != 0) moved = 1'b1;
    end
    if (inbox) begin
      if (pdsq <= rsq) begin
        hit = 1'b1;
      end else if (moved && dot >= 0 && $unsigned(dot) <= lensq) begin
        lhs = 128'(pdsq) * 128'(lensq);
        rhs = 128'(rsq) * 128'(lensq) + 128'(dot) * 128'(dot);
        hit = (lhs <= rhs);
      end
    end
    res.mark    = MARK_NONE;
    res.changed = 1'b0;
    res.cleaned = 1'b0;
    if (m == MARK_CLEANED) begin
      res.mark = MARK_CLEANED;
    end else if (hit) begin
      res.changed = 1'b1;
      if (clear_q) begin
        res.mark    = MARK_CLEANED;
        res.cleaned = 1'b1;
      end else begin
        res.mark = highlight_q;
      end
    end else if (m != MARK_NONE) begin
      res.changed = 1'b1;
    end
    return res;
  endfunction

  always @(negedge clk) begin
    mark_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_marks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("[%0t] unexpected result: mark_out=%0d changed=%0b cleaned=%0b",
                   $realtime, mark_out, mark_changed, cleaned_hit);
        end
      end else begin
        want = pending_marks.pop_front();
        if (mark_out !== want.mark || mark_changed !== want.changed ||
            cleaned_hit !== want.cleaned) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("[%0t] mismatch: mark/changed/cleaned exp %0d/%0b/%0b got %0d/%0b/%0b",
                     $realtime, want.mark, want.changed, want.cleaned, mark_out,
                     mark_changed, cleaned_hit);
          end
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge that takes the request.
  task automatic send_point(int x, int y, int z, mark_t m);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x  <= to_coord(x);
    point_y  <= to_coord(y);
    point_z  <= to_coord(z);
    mark_in  <= m;
    do @(negedge clk); while (!in_ready);
    pending_marks.insert(pending_marks.size(),
                         predict_mark(point_x, point_y, point_z, mark_in));
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    case (idx)
      CFG_CURSOR_NOW:    cursor_now_q    = data[CURSOR_W-1:0];
      CFG_CURSOR_BEFORE: cursor_before_q = data[CURSOR_W-1:0];
      CFG_BRUSH_RADIUS:  radius_q        = data[RAD_W-1:0];
      CFG_CLEAR_MODE:    clear_q         = data[0];
      CFG_HIGHLIGHT:     highlight_q     = data[MARK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic apply_settings(logic [CURSOR_W-1:0] now_bits, logic [CURSOR_W-1:0] before_bits,
                                int radius, logic clear, mark_t highlight);
    wait_drained();
    write_reg(CFG_CURSOR_NOW, CFG_DATA_W'(now_bits));
    write_reg(CFG_CURSOR_BEFORE, CFG_DATA_W'(before_bits));
    write_reg(CFG_BRUSH_RADIUS, CFG_DATA_W'(radius));
    write_reg(CFG_CLEAR_MODE, CFG_DATA_W'(clear));
    write_reg(CFG_HIGHLIGHT, CFG_DATA_W'(highlight));
    // A write past the last register must leave every setting alone.
    write_reg(CFG_IDX_W'($urandom_range(int'(CFG_HIGHLIGHT) + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  function automatic mark_t pick_mark();
    case ($urandom_range(0, 7))
      0, 1:    return MARK_NONE;
      2:       return MARK_CLEANED;
      3, 4, 5: return mark_t'($urandom_range(100, 199));
      default: return mark_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_setting(int kind);
    int                  cx, cy, cz, rad;
    logic [CURSOR_W-1:0] now_bits, before_bits;
    mark_t               hl;
    hl = ($urandom_range(0, 3) == 0) ? mark_t'($urandom_range(0, 255))
                                     : mark_t'($urandom_range(100, 199));
    case (kind)
      0: begin
        now_bits    = CURSOR_W'({$urandom, $urandom});
        before_bits = CURSOR_W'({$urandom, $urandom});
        rad         = (1 << RAD_W) - 1;
      end
      1: begin
        cx          = int'($urandom_range(0, 4000)) - 2000;
        cy          = int'($urandom_range(0, 4000)) - 2000;
        cz          = int'($urandom_range(0, 4000)) - 2000;
        now_bits    = pack_cursor(cx, cy, cz);
        before_bits = now_bits;
        rad         = 0;
      end
      default: begin
        cx       = int'($urandom_range(0, 40000)) - 20000;
        cy       = int'($urandom_range(0, 40000)) - 20000;
        cz       = int'($urandom_range(0, 40000)) - 20000;
        now_bits = pack_cursor(cx, cy, cz);
        if ($urandom_range(0, 3) == 0) begin
          before_bits = now_bits;
        end else begin
          before_bits = pack_cursor(cx + int'($urandom_range(0, 6000)) - 3000,
                                    cy + int'($urandom_range(0, 6000)) - 3000,
                                    cz + int'($urandom_range(0, 6000)) - 3000);
        end
        rad = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, (1 << RAD_W) - 1))
                                          : int'($urandom_range(0, 2000));
      end
    endcase
    apply_settings(now_bits, before_bits, rad, 1'($urandom_range(0, 1)), hl);
  endtask

  // Mostly points scattered around the swept path, so that the box, sphere
  // and cylinder boundaries all get exercised; the rest is uniform noise.
  task automatic random_points(int n);
    int q[3];
    int t, span;
    longint c, l;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        for (int i = 0; i < 3; i++) q[i] = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        t    = int'($urandom_range(0, 80)) - 8;
        span = int'(radius_q) + int'(radius_q) / 2 + 2;
        for (int i = 0; i < 3; i++) begin
          c    = lane_of(cursor_now_q, i);
          l    = lane_of(cursor_before_q, i);
          q[i] = int'(c + (l - c) * t / 64) + int'($urandom_range(0, 2 * span)) - span;
        end
      end
      send_point(q[0], q[1], q[2], pick_mark());
    end
  endtask

  task automatic test_reset_defaults();
    send_point(0, 0, 0, MARK_NONE);
    send_point(0, 0, 0, MARK_CLEANED);
    send_point(1, 0, 0, MARK_NONE);
    send_point(0, -1, 0, mark_t'(150));
    send_point(-32768, 32767, 0, mark_t'(255));
  endtask

  task automatic test_directed_geometry();
    // Cursor at rest with the widest brush.
    apply_settings(pack_cursor(0, 0, 0), pack_cursor(0, 0, 0), (1 << RAD_W) - 1, 1'b0,
                   mark_t'(199));
    send_point(32767, 32767, 32767, MARK_NONE);
    send_point(-32768, 0, 0, mark_t'(100));
    send_point(20000, -20000, 0, MARK_NONE);
    send_point(32767, 0, 0, MARK_CLEANED);
    // Longest possible sweep with zero radius: only exact contact with the segment hits.
    apply_settings(pack_cursor(-32768, -32768, -32768), pack_cursor(32767, 32767, 32767), 0,
                   1'b1, mark_t'(0));
    send_point(0, 0, 0, MARK_NONE);
    send_point(-1, -1, -1, mark_t'(255));
    send_point(0, 0, 1, mark_t'(150));
    send_point(32767, 32767, 32767, MARK_NONE);
    send_point(-32768, -32768, -32768, mark_t'(100));
    // Short sweep along x: behind the cursor, past the far end, and on the cylinder wall.
    apply_settings(pack_cursor(0, 0, 0), pack_cursor(1000, 0, 0), 100, 1'b0, mark_t'(0));
    send_point(-50, 0, 0, MARK_NONE);
    send_point(-90, 60, 0, MARK_NONE);
    send_point(1050, 0, 0, mark_t'(7));
    send_point(500, 100, 0, MARK_NONE);
    send_point(500, 101, 0, mark_t'(120));
    send_point(-150, 0, 0, mark_t'(130));
    apply_settings(pack_cursor(1234, -567, 89), pack_cursor(1234, -567, 89), 1, 1'b0,
                   mark_t'(255));
    send_point(1235, -567, 89, MARK_NONE);
    send_point(1235, -566, 89, MARK_NONE);
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int k = 0; k < 4; k++) begin
      random_setting(k);
      random_points(28);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_geometry();
    test_random_traffic(0, 0);
    test_random_traffic(81, 0);
    test_random_traffic(0, 81);
    test_random_traffic(29, 29);
    in_valid <= 1'b0;
    while (pending_marks.size() != 0) @(posedge clk);
    repeat (LATENCY * 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
